>>> hdl/swac_pkg.sv
// Package for the sliding window arrival counter.
// Holds sizes, item and ring request types, state encoding and slot helper.
// No dependencies.
package swac_pkg;

  localparam int RING_DEPTH  = 1024;
  localparam int SLOT_BITS   = $clog2(RING_DEPTH);
  localparam int HELD_BITS   = $clog2(RING_DEPTH + 1);
  localparam int TIME_BITS   = 48;
  localparam int WIDTH_BITS  = 32;
  localparam int INDEX_BITS  = 32;
  localparam int COUNT_BITS  = 11;
  localparam int AGE_BITS    = (TIME_BITS > WIDTH_BITS) ? TIME_BITS : WIDTH_BITS;

  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(1000);
  localparam logic [HELD_BITS-1:0]  HELD_FULL   = HELD_BITS'(RING_DEPTH);
  localparam logic [SLOT_BITS-1:0]  SLOT_LAST   = SLOT_BITS'(RING_DEPTH - 1);

  typedef struct packed {
    logic [TIME_BITS-1:0] timestamp;
    logic                 last_item;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] window_count;
    logic [COUNT_BITS-1:0] max_count;
    logic [INDEX_BITS-1:0] best_start;
    logic                  overflow;
  } out_item_t;

  typedef struct packed {
    logic                 wr_en;
    logic [SLOT_BITS-1:0] wr_slot;
    logic [TIME_BITS-1:0] wr_time;
    logic [SLOT_BITS-1:0] rd_slot;
  } ring_req_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  function automatic logic [SLOT_BITS-1:0] next_slot(input logic [SLOT_BITS-1:0] slot);
    next_slot = (slot == SLOT_LAST) ? '0 : slot + SLOT_BITS'(1);
  endfunction

endpackage

>>> hdl/swac_ring.sv
// Timestamp ring: one write port, one read port with registered read data.
// Depends on swac_pkg for sizes and the request struct.
module swac_ring (
  input  logic                          clk,
  input  swac_pkg::ring_req_t           req,
  output logic [swac_pkg::TIME_BITS-1:0] rdata
);

  logic [swac_pkg::TIME_BITS-1:0] mem [swac_pkg::RING_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_slot] <= req.wr_time;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[req.rd_slot];
  end

endmodule

>>> hdl/swac_ctrl.sv
// Window controller: tail scan over the ring, ring-full handling, best tracking.
// Depends on swac_pkg; drives the request port of swac_ring.
module swac_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  swac_pkg::in_item_t              in_data,
  input  logic [swac_pkg::WIDTH_BITS-1:0] window_width,
  input  logic                            out_free,
  output logic                            res_load,
  output swac_pkg::out_item_t             res_data,
  output swac_pkg::ring_req_t             ring_req,
  input  logic [swac_pkg::TIME_BITS-1:0]  ring_rdata
);

  swac_pkg::state_t                 state, state_next;
  logic [swac_pkg::TIME_BITS-1:0]   cur_time;
  logic                             cur_last;
  logic [swac_pkg::SLOT_BITS-1:0]   tail_slot;
  logic [swac_pkg::SLOT_BITS-1:0]   head_slot;
  logic [swac_pkg::HELD_BITS-1:0]   held;
  logic [swac_pkg::INDEX_BITS-1:0]  oldest_index;
  logic [swac_pkg::HELD_BITS-1:0]   best_count;
  logic [swac_pkg::INDEX_BITS-1:0]  best_start;
  logic                             overflow_seen;

  logic [swac_pkg::AGE_BITS-1:0]    age;
  logic                             do_drop;
  logic                             do_finish;
  logic                             full;
  logic [swac_pkg::HELD_BITS-1:0]   held_eff;
  logic [swac_pkg::INDEX_BITS-1:0]  tail_eff;
  logic [swac_pkg::SLOT_BITS-1:0]   tslot_eff;
  logic [swac_pkg::HELD_BITS-1:0]   count;
  logic                             best_hit;
  logic [swac_pkg::HELD_BITS-1:0]   best_count_next;
  logic [swac_pkg::INDEX_BITS-1:0]  best_start_next;

  assign age = swac_pkg::AGE_BITS'(cur_time) - swac_pkg::AGE_BITS'(ring_rdata);

  // Drop the tail entry once its age has reached the window width.
  assign do_drop = (state == swac_pkg::ST_SCAN) && (held != '0) &&
                   (cur_time >= ring_rdata) &&
                   (age >= swac_pkg::AGE_BITS'(window_width));

  assign do_finish = (state == swac_pkg::ST_SCAN) && !do_drop && out_free;

  // Ring still full after the scan: overwrite the oldest entry.
  assign full      = (held == swac_pkg::HELD_FULL);
  assign held_eff  = full ? held - swac_pkg::HELD_BITS'(1) : held;
  assign tail_eff  = full ? oldest_index + swac_pkg::INDEX_BITS'(1) : oldest_index;
  assign tslot_eff = full ? swac_pkg::next_slot(tail_slot) : tail_slot;
  assign count     = held_eff + swac_pkg::HELD_BITS'(1);
  assign best_hit  = count > best_count;

  assign best_count_next = best_hit ? count : best_count;
  assign best_start_next = best_hit ? tail_eff : best_start;

  assign res_load = do_finish;
  assign res_data = '{
    window_count: swac_pkg::COUNT_BITS'(count),
    max_count:    swac_pkg::COUNT_BITS'(best_count_next),
    best_start:   best_start_next,
    overflow:     overflow_seen | full
  };

  // Read ahead at the next tail slot while dropping so the scan runs one entry per cycle.
  assign ring_req = '{
    wr_en:   do_finish,
    wr_slot: head_slot,
    wr_time: cur_time,
    rd_slot: do_drop ? swac_pkg::next_slot(tail_slot) : tail_slot
  };

  assign in_stall = (state != swac_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swac_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      swac_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = swac_pkg::ST_SCAN;
        end
      end
      swac_pkg::ST_SCAN: begin
        if (do_finish) begin
          state_next = swac_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = swac_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == swac_pkg::ST_IDLE && in_valid) begin
      cur_time <= in_data.timestamp;
      cur_last <= in_data.last_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tail_slot     <= '0;
      head_slot     <= '0;
      held          <= '0;
      oldest_index  <= '0;
      best_count    <= '0;
      best_start    <= '0;
      overflow_seen <= 1'b0;
    end else if (do_drop) begin
      tail_slot    <= swac_pkg::next_slot(tail_slot);
      oldest_index <= oldest_index + swac_pkg::INDEX_BITS'(1);
      held         <= held - swac_pkg::HELD_BITS'(1);
    end else if (do_finish) begin
      if (cur_last) begin
        tail_slot     <= '0;
        head_slot     <= '0;
        held          <= '0;
        oldest_index  <= '0;
        best_count    <= '0;
        best_start    <= '0;
        overflow_seen <= 1'b0;
      end else begin
        tail_slot     <= tslot_eff;
        head_slot     <= swac_pkg::next_slot(head_slot);
        held          <= count;
        oldest_index  <= tail_eff;
        best_count    <= best_count_next;
        best_start    <= best_start_next;
        overflow_seen <= overflow_seen | full;
      end
    end
  end

endmodule

>>> hdl/sliding_window_arrival_count_max.sv
// A new item is taken only in idle, once the tail scan for the last one has ended;
// the tail scan reads one ring entry per cycle through the single read port.
// The result enters the output register when the scan ends and the output is free.
// Input is taken while an earlier result still waits; a result waits for the output.
// Reset clears pointers, best tracking and the width register (1000); ring contents
// stay undefined and are only read after being written in the current set.
module sliding_window_arrival_count_max_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  swac_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output swac_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [swac_pkg::WIDTH_BITS-1:0] cfg_data
);

  logic [swac_pkg::WIDTH_BITS-1:0] window_width;
  logic                            out_free;
  logic                            res_load;
  swac_pkg::out_item_t             res_data;
  swac_pkg::ring_req_t             ring_req;
  logic [swac_pkg::TIME_BITS-1:0]  ring_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_width <= swac_pkg::WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      window_width <= cfg_data;
    end
  end

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data <= res_data;
    end
  end

  swac_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .window_width (window_width),
    .out_free     (out_free),
    .res_load     (res_load),
    .res_data     (res_data),
    .ring_req     (ring_req),
    .ring_rdata   (ring_rdata)
  );

  swac_ring u_ring (
    .clk   (clk),
    .req   (ring_req),
    .rdata (ring_rdata)
  );

  a_load_into_free: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!out_valid || !out_stall))
    else $error("result loaded over a stalled item");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not held off after accept");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    res_load |=> out_valid)
    else $error("loaded result not presented");

  a_write_on_load: assert property (@(posedge clk) disable iff (rst)
    ring_req.wr_en |-> res_load)
    else $error("ring written without a result");

endmodule
